/* sv/stm_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse table range minimum: shared package
// Entry type, operation codes, fixed widths and the pair ordering used by
// both the build sweep and the query compare.
// ----------------------------------------------------------------------------
package stm_pkg;

   // Fixed widths of the stream fields.
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // Operation codes carried in req_tuser.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_BUILD = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // One table entry: a value and the position it came from.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [POS_W-1:0]   position;
   } entry_type;

   localparam entry_type SENTINEL = '{value: 32'sh3f3f3f3f, position: -11'sd1};
   localparam entry_type BAD_RESULT = '{value: 32'sd0, position: -11'sd1};

   // True when entry a orders strictly below entry b; ties go to the lower position.
   function automatic logic pair_less(input entry_type a, input entry_type b);
      logic less;
      if (a.value != b.value) begin
         less = (a.value < b.value);
      end else begin
         less = (a.position < b.position);
      end
      return less;
   endfunction

   // Smaller of two entries, the first one when they are equal.
   function automatic entry_type pair_min(input entry_type a, input entry_type b);
      return pair_less(b, a) ? b : a;
   endfunction

endpackage

/* sv/stm_table.sv */
// ----------------------------------------------------------------------------
// Sparse table range minimum: level table
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module stm_table #(
   parameter int AW    = 14,
   parameter int DEPTH = 11264
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  stm_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output stm_pkg::entry_type  rd_data_a,
   output stm_pkg::entry_type  rd_data_b
);
   import stm_pkg::*;

   entry_type mem [0:DEPTH-1];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* sv/stm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sparse table range minimum: sequencer
// Runs the clear and build sweeps over the table, handles set writes and
// query reads, and holds the result register.
// ----------------------------------------------------------------------------
module stm_ctrl #(
   parameter int MAX_ELEMS = 1024,
   parameter int LEVELS    = 11,
   parameter int JW        = 10,
   parameter int LW        = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [stm_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [stm_pkg::VALUE_W-1:0] req_value,
   input  logic [stm_pkg::INDEX_W-1:0]       req_left,
   input  logic [stm_pkg::INDEX_W-1:0]       req_right,
   input  logic [stm_pkg::COUNT_W-1:0]       used_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output stm_pkg::entry_type                rsp_entry,
   output logic                              rsp_bad,
   output logic                              wr_en,
   output logic [LW+JW-1:0]                  wr_addr,
   output stm_pkg::entry_type                wr_data,
   output logic                              rd_en,
   output logic [LW+JW-1:0]                  rd_addr_a,
   output logic [LW+JW-1:0]                  rd_addr_b,
   input  stm_pkg::entry_type                rd_data_a,
   input  stm_pkg::entry_type                rd_data_b
);
   import stm_pkg::*;

   localparam int XW = (JW > COUNT_W) ? JW : COUNT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_BUILD  = 3'd2;
   localparam logic [2:0] ST_GAP    = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [LW-1:0]     level_ff, level_in;
   logic [JW-1:0]     j_ff, j_in;
   logic              wpend_ff, wpend_in;
   logic [LW+JW-1:0]  waddr_ff, waddr_in;
   logic              qbad_ff, qbad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic              accept;
   logic              q_bad;
   logic [COUNT_W-1:0] q_len;
   int                q_msb;
   int                q_blk;
   logic [LW-1:0]     q_level;
   logic [COUNT_W-1:0] q_start_b;
   logic [XW-1:0]     b_half;
   logic [XW-1:0]     b_last;
   logic [XW-1:0]     c_last;
   logic [LW-1:0]     level_dn;
   logic [LW:0]       level_up;
   logic              set_ok;
   logic              rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Query block selection: range check, block level and the second block start.
   always_comb begin
      q_bad = (req_left > req_right) || ({1'b0, req_right} >= used_count);
      q_len = {1'b0, req_right} - {1'b0, req_left} + COUNT_W'(1);
      q_msb = 0;
      for (int i = 0; i < COUNT_W; i++) begin
         if (q_len[i]) begin
            q_msb = i;
         end
      end
      q_blk     = (q_msb > LEVELS - 1) ? LEVELS - 1 : q_msb;
      q_level   = LW'(q_blk);
      q_start_b = {1'b0, req_right} + COUNT_W'(1) - (COUNT_W'(1) << q_blk);
   end

   // Build and clear sweep bounds.
   assign level_dn = level_ff - LW'(1);
   assign level_up = {1'b0, level_ff} + (LW+1)'(1);
   assign b_half   = XW'(1) << level_dn;
   assign b_last   = XW'(used_count) - (XW'(1) << level_ff);
   assign c_last   = XW'(used_count) - XW'(1);
   assign set_ok   = (32'(req_index) < 32'(MAX_ELEMS));

   // Memory write port: set, clear sweep or the pending build result.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = waddr_ff;
      wr_data = pair_min(rd_data_a, rd_data_b);
      if (wpend_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = {level_ff, j_ff};
         wr_data = SENTINEL;
      end else if (accept && (req_opcode == OP_SET) && set_ok) begin
         wr_en   = 1'b1;
         wr_addr = {LW'(0), JW'(req_index)};
         wr_data = '{value: req_value, position: {1'b0, req_index}};
      end
   end

   // Memory read ports: the two halves during build, the two blocks of a query.
   always_comb begin
      if (state_ff == ST_BUILD) begin
         rd_en     = 1'b1;
         rd_addr_a = {level_dn, j_ff};
         rd_addr_b = {level_dn, JW'(XW'(j_ff) + b_half)};
      end else begin
         rd_en     = accept && (req_opcode == OP_QUERY) && !q_bad;
         rd_addr_a = {q_level, JW'(req_left)};
         rd_addr_b = {q_level, JW'(q_start_b)};
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      j_in         = j_ff;
      wpend_in     = 1'b0;
      waddr_in     = waddr_ff;
      qbad_in      = qbad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_entry_in = rsp_entry_ff;
      rsp_bad_in   = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               level_in = '0;
               j_in     = '0;
               case (req_opcode)
                  OP_CLEAR: begin
                     if (used_count != '0) begin
                        state_in = ST_CLEAR;
                     end
                  end
                  OP_BUILD: begin
                     if (used_count >= COUNT_W'(2)) begin
                        state_in = ST_BUILD;
                        level_in = LW'(1);
                     end
                  end
                  OP_QUERY: begin
                     qbad_in  = q_bad;
                     state_in = ST_RESULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            if (XW'(j_ff) == c_last) begin
               j_in = '0;
               if (level_ff == LW'(LEVELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  level_in = level_ff + LW'(1);
               end
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         ST_BUILD: begin
            wpend_in = 1'b1;
            waddr_in = {level_ff, j_ff};
            if (XW'(j_ff) == b_last) begin
               state_in = ST_GAP;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         ST_GAP: begin
            // The last write of a level lands here, before the next level reads it.
            j_in = '0;
            if (level_ff == LW'(LEVELS - 1)) begin
               state_in = ST_IDLE;
            end else if ((used_count >> level_up) != '0) begin
               state_in = ST_BUILD;
               level_in = LW'(level_up);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = qbad_ff;
               rsp_entry_in = qbad_ff ? BAD_RESULT : pair_min(rd_data_a, rd_data_b);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sweep counters and payload registers.
   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      j_ff         <= j_in;
      waddr_ff     <= waddr_in;
      qbad_ff      <= qbad_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry = rsp_entry_ff;
   assign rsp_bad   = rsp_bad_ff;

endmodule

/* sv/sparse_table_range_min_top.sv */
// A range query reads the table into its registered read ports on the transfer, then
// waits in the result state until the result register is free; set writes the table
// on its transfer. No request is taken until a query's result is registered. Clear
// runs one write per cycle, build fills each level k; nothing is accepted while a sweep runs.
// Reset: synchronous, active high; clears control state and sets the count to
// 1024. The table holds no defined contents until a clear has run.
// ----------------------------------------------------------------------------
// Sparse table range minimum: top level
// Stream ports, the element count register and the table memory.
// ----------------------------------------------------------------------------
module sparse_table_range_min_top #(
   parameter int MAX_ELEMS = 1024,
   parameter int LEVELS    = 11
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // index[9:0], value[41:10], left[51:42], right[61:52]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // min_value[31:0], min_position[42:32]
   output logic        rsp_tuser,  // bad_range[0]
   // Element count register.
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   import stm_pkg::*;

   localparam int JW    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int LW    = $clog2(LEVELS);
   localparam int AW    = LW + JW;
   localparam int DEPTH = LEVELS * (2 ** JW);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] used_count;

   logic       wr_en;
   logic [AW-1:0] wr_addr;
   entry_type  wr_data;
   logic       rd_en;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   entry_type  rd_data_a;
   entry_type  rd_data_b;
   entry_type  rsp_entry;
   logic       rsp_bad;

   // Element count register.
   assign count_in = csr_we ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // The count in use never exceeds the storage.
   always_comb begin
      if (32'(count_ff) > 32'(MAX_ELEMS)) begin
         used_count = COUNT_W'(MAX_ELEMS);
      end else begin
         used_count = count_ff;
      end
   end

   stm_ctrl #(
      .MAX_ELEMS (MAX_ELEMS),
      .LEVELS    (LEVELS),
      .JW        (JW),
      .LW        (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .req_index  (req_tdata[9:0]),
      .req_value  (req_tdata[41:10]),
      .req_left   (req_tdata[51:42]),
      .req_right  (req_tdata[61:52]),
      .used_count (used_count),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_entry  (rsp_entry),
      .rsp_bad    (rsp_bad),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b)
   );

   stm_table #(
      .AW    (AW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Result packing.
   assign rsp_tdata = {5'd0, rsp_entry.position, rsp_entry.value};
   assign rsp_tuser = rsp_bad;

endmodule

/* sim/tb_sparse_table_range_min_top.sv */
// ----------------------------------------------------------------------------
// Sparse table range minimum: top-level testbench
// Streams clear, set, build and range query requests into the block through
// a queue-fed driver and checks every query answer against a predictor that
// keeps its own copy of the level table and the element count. The run covers
// directed corner cases first, then randomized phases at several counts, with
// random idle gaps on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_sparse_table_range_min_top;
   timeunit 1ns;
   timeprecision 1ps;

   import stm_pkg::*;

   localparam int MAX_ELEMS    = 1024;
   localparam int LEVELS       = 11;
   localparam int ITEM_TARGET  = 1650;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int END_CYCLES   = 20;

   localparam logic signed [VALUE_W-1:0] FILL_VALUE  = 32'sh3f3f3f3f;
   localparam logic signed [POS_W-1:0]   NO_POSITION = -11'sd1;

   // One request as the stream carries it.
   typedef struct packed {
      logic [1:0]                opcode;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        range_left;
      logic [INDEX_W-1:0]        range_right;
   } request_type;

   // A value and the position it came from, as held in each level.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [POS_W-1:0]   position;
   } pair_type;

   // Answer to one range query.
   typedef struct packed {
      pair_type best;
      logic     bad_range;
   } answer_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata  = '0;  // index[9:0], value[41:10], left[51:42], right[61:52]
   logic [1:0]          req_tuser  = OP_CLEAR;  // opcode[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;        // min_value[31:0], min_position[42:32]
   logic                rsp_tuser;        // bad_range[0]
   logic                csr_we     = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata  = '0;

   // Predictor state.
   pair_type            level_copy [LEVELS][MAX_ELEMS];
   logic [COUNT_W-1:0]  count_copy = COUNT_RESET;

   request_type         pending_requests [$];
   answer_type          expected_answers [$];
   request_type         driven_item;

   int                  tx_gap_left   = 0;
   int                  rx_gap_left   = 0;
   int                  rsp_hold_left = 0;
   bit                  tx_idle_on    = 1'b1;
   bit                  rx_idle_on    = 1'b1;
   int                  error_count   = 0;
   int                  items_queued  = 0;
   int                  cleared_span  = 0;

   sparse_table_range_min_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog for a hung run.
   initial begin
      #100_000_000;
      $display("tb_sparse_table_range_min_top: errors");
      $finish;
   end

   // Pair order: by value, then by position, so ties go to the lower position.
   function automatic bit pair_below(input pair_type a, input pair_type b);
      if (a.value != b.value) begin
         return $signed(a.value) < $signed(b.value);
      end
      return $signed(a.position) < $signed(b.position);
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Apply one accepted transfer to the table copy and queue its answer.
   task automatic apply_request(input request_type item);
      int          used;
      int          k;
      int          j;
      int          span;
      int          len;
      int          blk;
      pair_type    lo_half;
      pair_type    hi_half;
      answer_type  ans;
      used = (count_copy > MAX_ELEMS) ? MAX_ELEMS : int'(count_copy);
      case (item.opcode)
         OP_CLEAR: begin
            for (k = 0; k < LEVELS; k++) begin
               for (j = 0; j < used; j++) begin
                  level_copy[k][j] = '{value: FILL_VALUE, position: NO_POSITION};
               end
            end
         end
         OP_SET: begin
            level_copy[0][item.index] = '{value: item.value, position: {1'b0, item.index}};
         end
         OP_BUILD: begin
            for (k = 1; k < LEVELS; k++) begin
               span = 1 << k;
               for (j = 0; j + span <= used; j++) begin
                  lo_half = level_copy[k-1][j];
                  hi_half = level_copy[k-1][j + span / 2];
                  level_copy[k][j] = pair_below(hi_half, lo_half) ? hi_half : lo_half;
               end
            end
         end
         default: begin
            if (item.range_left > item.range_right || int'(item.range_right) >= used) begin
               ans.best      = '{value: '0, position: NO_POSITION};
               ans.bad_range = 1'b1;
            end else begin
               len = int'(item.range_right) - int'(item.range_left) + 1;
               blk = 0;
               while (blk + 1 < LEVELS && (1 << (blk + 1)) <= len) blk++;
               lo_half = level_copy[blk][item.range_left];
               hi_half = level_copy[blk][int'(item.range_right) + 1 - (1 << blk)];
               ans.best      = pair_below(hi_half, lo_half) ? hi_half : lo_half;
               ans.bad_range = 1'b0;
            end
            expected_answers.push_back(ans);
         end
      endcase
   endtask

   task automatic note_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   // Request driver: holds each transfer until accepted, then idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(driven_item);
         end
         if (!req_tvalid || req_tready) begin
            if (tx_gap_left != 0) begin
               tx_gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               driven_item = pending_requests.pop_front();
               req_tdata  <= {2'b00, driven_item.range_right, driven_item.range_left,
                              driven_item.value, driven_item.index};
               req_tuser  <= driven_item.opcode;
               req_tvalid <= 1'b1;
               tx_gap_left = tx_idle_on ? idle_length() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long result-side hold-off, counted down here.
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   // Result monitor: checks each transfer against the oldest expected answer.
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_gap_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               note_mismatch($sformatf("result with nothing expected: tdata %h tuser %b",
                                       rsp_tdata, rsp_tuser));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata[31:0] !== want.best.value ||
                   rsp_tdata[42:32] !== want.best.position ||
                   rsp_tuser !== want.bad_range) begin
                  note_mismatch($sformatf(
                     "expected value %0d position %0d bad %0b, got value %0d position %0d bad %0b",
                     want.best.value, want.best.position, want.bad_range,
                     $signed(rsp_tdata[31:0]), $signed(rsp_tdata[42:32]), rsp_tuser));
               end
            end
         end
         if (rsp_hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (!rx_idle_on) begin
            rsp_tready <= 1'b1;
         end else if (rx_gap_left != 0) begin
            rx_gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap_left = idle_length();
         end
      end
   end

   // Random value biased toward extremes, the fill value and small ties.
   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)  return 32'h8000_0000;
      if (r < 8)  return 32'h7fff_ffff;
      if (r < 12) return FILL_VALUE;
      if (r < 40) return 32'($urandom_range(0, 7));
      return $urandom;
   endfunction

   function automatic request_type noise_item(input logic [1:0] op);
      request_type it;
      it.opcode      = op;
      it.index       = INDEX_W'($urandom);
      it.value       = $urandom;
      it.range_left  = INDEX_W'($urandom);
      it.range_right = INDEX_W'($urandom);
      return it;
   endfunction

   task automatic queue_item(input request_type item);
      pending_requests.push_back(item);
      items_queued++;
   endtask

   task automatic queue_op(input logic [1:0] op);
      queue_item(noise_item(op));
   endtask

   task automatic queue_set(input int idx, input logic [VALUE_W-1:0] val);
      request_type it;
      it       = noise_item(OP_SET);
      it.index = INDEX_W'(idx);
      it.value = val;
      queue_item(it);
   endtask

   task automatic queue_query(input int lo, input int hi);
      request_type it;
      it             = noise_item(OP_QUERY);
      it.range_left  = INDEX_W'(lo);
      it.range_right = INDEX_W'(hi);
      queue_item(it);
   endtask

   // Query inside the used part of the table.
   task automatic queue_valid_query(input int used);
      int lo;
      int hi;
      int r;
      lo = $urandom_range(0, used - 1);
      r  = $urandom_range(0, 9);
      if (r < 2) hi = lo;
      else if (r < 4) hi = used - 1;
      else hi = $urandom_range(lo, used - 1);
      queue_query(lo, hi);
   endtask

   task automatic queue_random_set(input int used);
      if (used > 0 && $urandom_range(0, 9) != 0) begin
         queue_set($urandom_range(0, used - 1), pick_value());
      end else begin
         queue_set($urandom_range(0, MAX_ELEMS - 1), pick_value());
      end
   endtask

   // A rejected range goes last: it is only taken once any sweep has finished,
   // so its answer arriving means the block is idle.
   task automatic drain();
      queue_query(1, 0);
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_answers.size() != 0);
   endtask

   // Element count write, only while the block is idle.
   task automatic write_count(input int count_value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= COUNT_W'(count_value);
      @(posedge clock);
      csr_we     <= 1'b0;
      count_copy  = COUNT_W'(count_value);
      @(negedge clock);
   endtask

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 48);
      if (r < 95) return $urandom_range(49, 256);
      return $urandom_range(257, 1024);
   endfunction

   // One randomized phase: optional clear, a burst of sets, usually a build, then a
   // mix dominated by valid queries with some noise.
   task automatic random_phase(input int count_value, input bit long_hold);
      int used;
      int nsets;
      int body_len;
      int i;
      int r;
      write_count(count_value);
      used       = (count_value > MAX_ELEMS) ? MAX_ELEMS : count_value;
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      body_len   = $urandom_range(30, 90);
      if (long_hold) begin
         // Receiver stops while the sender keeps offering queries.
         tx_idle_on = 1'b0;
         body_len   = 120;
         @(posedge clock);
         rsp_hold_left <= HOLD_CYCLES;
         @(negedge clock);
      end
      if (used > cleared_span || $urandom_range(0, 3) != 0) begin
         queue_op(OP_CLEAR);
         if (used > cleared_span) cleared_span = used;
      end
      nsets = $urandom_range(0, 24);
      for (i = 0; i < nsets; i++) queue_random_set(used);
      if ($urandom_range(0, 9) != 0) queue_op(OP_BUILD);
      for (i = 0; i < body_len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 62 && used > 0) queue_valid_query(used);
         else if (r < 72) queue_op(OP_QUERY);
         else if (r < 88) queue_random_set(used);
         else if (r < 96) queue_op(OP_BUILD);
         else queue_op(OP_CLEAR);
      end
      drain();
   endtask

   // Stimulus sequence and end of run.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset count: extremes, ties and the fill value.
      queue_op(OP_CLEAR);
      cleared_span = MAX_ELEMS;
      queue_set(0, 32'h8000_0000);
      queue_set(1023, 32'h7fff_ffff);
      queue_set(5, FILL_VALUE);
      queue_set(6, FILL_VALUE);
      queue_set(10, 32'd7);
      queue_set(12, 32'd7);
      queue_set(11, 32'd9);
      queue_query(0, 0);
      // Before a build the higher levels still hold the cleared fill pair.
      queue_query(3, 4);
      queue_query(0, 1023);
      queue_op(OP_BUILD);
      queue_query(0, 1023);
      queue_query(1023, 1023);
      queue_query(5, 6);
      // A cleared entry with no position wins over a set entry of equal value.
      queue_query(4, 7);
      queue_query(10, 12);
      queue_query(7, 3);
      queue_query(1023, 0);
      drain();

      // Smaller count without a clear: the build leaves upper entries stale.
      write_count(16);
      queue_set(3, -32'sd5);
      queue_op(OP_BUILD);
      queue_query(1, 15);
      queue_query(2, 16);
      drain();
      write_count(1024);
      queue_query(1, 1022);
      drain();

      // Randomized phases, the count extremes first.
      random_phase(0, 1'b0);
      random_phase(2047, 1'b0);
      random_phase(32, 1'b1);
      random_phase(1, 1'b0);
      random_phase(2, 1'b0);
      while (items_queued < ITEM_TARGET) random_phase(pick_count(), 1'b0);

      repeat (END_CYCLES) @(posedge clock);
      if (expected_answers.size() != 0) begin
         note_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));
      end
      if (error_count == 0) begin
         $display("tb_sparse_table_range_min_top: clean");
      end else begin
         $display("tb_sparse_table_range_min_top: errors");
      end
      $finish;
   end

endmodule
